// ===== rtl/frmt_pkg.sv =====
// Shared types and constants for the frame region MRU table.
// Holds the request, response and table entry structs and the rank command codes.
// Depends on nothing.
`default_nettype none

package frmt_pkg;

   localparam int ADDR_W = 24;
   localparam int END_W  = 25;
   localparam int DIM_W  = 10;
   localparam int PSZ_W  = 2;
   localparam int SLOT_W = 4;
   localparam int PROD_W = 2 * DIM_W;

   typedef enum logic [1:0] {
      OP_SAVE   = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  address;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [PSZ_W-1:0]   pixel_size;
      logic [DIM_W-1:0]   prev_image_height;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [ADDR_W-1:0]  region_start;
      logic [END_W-1:0]   region_end;
      logic [DIM_W-1:0]   region_width;
      logic [PSZ_W-1:0]   region_size;
      logic               created;
      logic               resized;
      logic               evicted;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  region_start;
      logic [END_W-1:0]   region_end;
      logic [DIM_W-1:0]   region_width;
      logic [PSZ_W-1:0]   region_size;
   } entry_type;

   typedef enum logic [2:0] {
      RK_NONE   = 3'd0,
      RK_CLEAR  = 3'd1,
      RK_DROP   = 3'd2,
      RK_RAISE  = 3'd3,
      RK_INSERT = 3'd4
   } rank_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/frmt_store.sv =====
// Region entry memory: one write port and one registered read port.
// Uses frmt_pkg for the entry layout.
`default_nettype none

module frmt_store #(
   parameter int ENTRIES = 16
) (
   input  wire logic                         clock,
   input  wire logic [$clog2(ENTRIES)-1:0]   rd_addr,
   output frmt_pkg::entry_type               rd_data,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0]   wr_addr,
   input  wire frmt_pkg::entry_type          wr_data
);

   frmt_pkg::entry_type mem [ENTRIES];
   frmt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/frmt_rank.sv =====
// Valid bits and recency ranks of all slots, updated in parallel per command.
// Uses frmt_pkg for the rank command codes.
`default_nettype none

module frmt_rank #(
   parameter int ENTRIES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire frmt_pkg::rank_cmd_type       cmd,
   input  wire logic [$clog2(ENTRIES)-1:0]   cmd_slot,
   input  wire logic [$clog2(ENTRIES)-1:0]   cmd_rank,
   input  wire logic [$clog2(ENTRIES)-1:0]   rd_idx,
   output logic                              rd_valid,
   output logic [$clog2(ENTRIES)-1:0]        rd_rank
);

   localparam int RW = $clog2(ENTRIES);

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [RW-1:0]      rank_ff [ENTRIES];
   logic [RW-1:0]      rank_in [ENTRIES];

   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         valid_in[j] = valid_ff[j];
         rank_in[j]  = rank_ff[j];
         case (cmd)
            frmt_pkg::RK_CLEAR: begin
               valid_in[j] = 1'b0;
            end
            frmt_pkg::RK_DROP: begin
               if (valid_ff[j] && (rank_ff[j] > cmd_rank)) begin
                  rank_in[j] = rank_ff[j] - RW'(1);
               end
               if (RW'(j) == cmd_slot) begin
                  valid_in[j] = 1'b0;
                  rank_in[j]  = '0;
               end
            end
            frmt_pkg::RK_RAISE: begin
               if (valid_ff[j] && (rank_ff[j] < cmd_rank)) begin
                  rank_in[j] = rank_ff[j] + RW'(1);
               end
               if (RW'(j) == cmd_slot) begin
                  rank_in[j] = '0;
               end
            end
            frmt_pkg::RK_INSERT: begin
               if (valid_ff[j]) begin
                  rank_in[j] = rank_ff[j] + RW'(1);
               end
               if (RW'(j) == cmd_slot) begin
                  valid_in[j] = 1'b1;
                  rank_in[j]  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/frmt_endcalc.sv =====
// Region end calculator: multiply width by height, then scale and add to the start.
// Two register stages; uses frmt_pkg for field widths.
`default_nettype none

module frmt_endcalc (
   input  wire logic                           clock,
   input  wire logic [frmt_pkg::ADDR_W-1:0]    start_addr,
   input  wire logic [frmt_pkg::DIM_W-1:0]     width,
   input  wire logic [frmt_pkg::DIM_W-1:0]     height,
   input  wire logic [frmt_pkg::PSZ_W-1:0]     size,
   output logic [frmt_pkg::END_W-1:0]          end_addr
);

   localparam int PW = frmt_pkg::PROD_W;
   localparam int EW = frmt_pkg::END_W;

   logic [PW-1:0]                 prod_ff;
   logic [PW-1:0]                 prod_in;
   logic [frmt_pkg::ADDR_W-1:0]   start_ff;
   logic [frmt_pkg::PSZ_W-1:0]    size_ff;
   logic [PW+2:0]                 scaled;
   logic [EW-1:0]                 end_ff;
   logic [EW-1:0]                 end_in;

   assign prod_in = PW'(width) * PW'(height);

   always_comb begin
      scaled = {3'b000, prod_ff} << size_ff;
      end_in = EW'(start_ff) + EW'(scaled[PW+2:1]) - EW'(1);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      start_ff <= start_addr;
      size_ff  <= size;
      end_ff   <= end_in;
   end

   assign end_addr = end_ff;

endmodule

`default_nettype wire

// ===== rtl/frame_region_mru_table_top.sv =====
// Frame region MRU table: sequencer that walks the slots one per cycle through the
// entry memory's single read port, sharing one compare unit and one end calculator.
// Find and remove: scan every slot, then strobe from the decide state. Save: the same scan,
// after a trim of the top region and before a create state when needed. Flush: strobe registered at the accepting edge.
// The block takes one item at a time; busy is high until the strobe cycle.
// Synchronous reset empties the table at once; entry contents are not cleared.
`default_nettype none

module frame_region_mru_table_top #(
   parameter int ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire frmt_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output frmt_pkg::rsp_type      rsp_data
);

   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SW = frmt_pkg::SLOT_W;
   localparam int EW = frmt_pkg::END_W;
   localparam int DW = frmt_pkg::DIM_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIM_MUL,
      S_TRIM_ADD,
      S_TRIM_WR,
      S_SCAN,
      S_SCAN_LAST,
      S_DECIDE,
      S_CREATE
   } state_type;

   state_type               state_ff, state_in;
   frmt_pkg::req_type       req_ff, req_in;
   logic [RW-1:0]           idx_ff, idx_in;
   logic                    chk_ff, chk_in;
   logic [RW-1:0]           chk_idx_ff, chk_idx_in;
   logic                    found_ff, found_in;
   logic [RW-1:0]           best_slot_ff, best_slot_in;
   logic [RW-1:0]           best_rank_ff, best_rank_in;
   frmt_pkg::entry_type     best_ent_ff, best_ent_in;
   logic                    free_found_ff, free_found_in;
   logic [RW-1:0]           free_slot_ff, free_slot_in;
   logic [RW-1:0]           aux_slot_ff, aux_slot_in;
   logic [RW-1:0]           new_slot_ff, new_slot_in;
   logic                    evict_ff, evict_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [RW-1:0]           top_ff, top_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   frmt_pkg::rsp_type       rsp_ff, rsp_in;

   logic [RW-1:0]           rd_addr;
   frmt_pkg::entry_type     rd_data;
   logic                    wr_en;
   logic [RW-1:0]           wr_addr;
   frmt_pkg::entry_type     wr_data;
   frmt_pkg::rank_cmd_type  rk_cmd;
   logic [RW-1:0]           rk_slot;
   logic [RW-1:0]           rk_rank;
   logic                    rk_valid;
   logic [RW-1:0]           rk_rank_rd;
   logic [frmt_pkg::ADDR_W-1:0] calc_start;
   logic [DW-1:0]           calc_w;
   logic [DW-1:0]           calc_h;
   logic [frmt_pkg::PSZ_W-1:0]  calc_sz;
   logic [EW-1:0]           calc_end;
   logic [RW-1:0]           aux_target;
   logic                    contains;
   logic                    cand;
   logic                    better;

   frmt_store #(.ENTRIES(ENTRIES)) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   frmt_rank #(.ENTRIES(ENTRIES)) u_rank (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rk_cmd),
      .cmd_slot (rk_slot),
      .cmd_rank (rk_rank),
      .rd_idx   (chk_idx_ff),
      .rd_valid (rk_valid),
      .rd_rank  (rk_rank_rd)
   );

   frmt_endcalc u_endcalc (
      .clock      (clock),
      .start_addr (calc_start),
      .width      (calc_w),
      .height     (calc_h),
      .size       (calc_sz),
      .end_addr   (calc_end)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      best_slot_in  = best_slot_ff;
      best_rank_in  = best_rank_ff;
      best_ent_in   = best_ent_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      aux_slot_in   = aux_slot_ff;
      new_slot_in   = new_slot_ff;
      evict_in      = evict_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = best_slot_ff;
      wr_data       = best_ent_ff;
      rk_cmd        = frmt_pkg::RK_NONE;
      rk_slot       = best_slot_ff;
      rk_rank       = best_rank_ff;
      calc_start    = req_ff.address;
      calc_w        = req_ff.width;
      calc_h        = req_ff.height;
      calc_sz       = req_ff.pixel_size;

      aux_target = (req_ff.op == frmt_pkg::OP_REMOVE) ? RW'(1) : RW'(count_ff - CW'(1));
      contains   = (rd_data.region_start <= req_ff.address) &&
                   (rd_data.region_end >= EW'(req_ff.address));
      if (req_ff.op == frmt_pkg::OP_REMOVE) begin
         cand   = rk_valid && (rd_data.region_start == req_ff.address);
         better = !found_ff || (rk_rank_rd > best_rank_ff);
      end else begin
         cand   = rk_valid && contains;
         better = !found_ff || (rk_rank_rd < best_rank_ff);
      end

      if (chk_ff) begin
         if (cand && better) begin
            found_in     = 1'b1;
            best_slot_in = chk_idx_ff;
            best_rank_in = rk_rank_rd;
            best_ent_in  = rd_data;
         end
         if (!rk_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = chk_idx_ff;
         end
         if (rk_valid && (rk_rank_rd == aux_target)) begin
            aux_slot_in = chk_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = top_ff;
            if (start) begin
               req_in        = req_data;
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               evict_in      = 1'b0;
               case (req_data.op)
                  frmt_pkg::OP_FLUSH: begin
                     rk_cmd        = frmt_pkg::RK_CLEAR;
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                  end
                  frmt_pkg::OP_SAVE: begin
                     if ((count_ff != '0) && (req_data.prev_image_height > DW'(1))) begin
                        state_in = S_TRIM_MUL;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_TRIM_MUL: begin
            calc_start  = rd_data.region_start;
            calc_w      = rd_data.region_width;
            calc_h      = req_ff.prev_image_height;
            calc_sz     = rd_data.region_size;
            best_ent_in = rd_data;
            state_in    = S_TRIM_ADD;
         end
         S_TRIM_ADD: begin
            state_in = S_TRIM_WR;
         end
         S_TRIM_WR: begin
            wr_en              = 1'b1;
            wr_addr            = top_ff;
            wr_data            = best_ent_ff;
            wr_data.region_end = calc_end;
            state_in           = S_SCAN;
         end
         S_SCAN: begin
            rd_addr    = idx_ff;
            chk_in     = 1'b1;
            chk_idx_in = idx_ff;
            idx_in     = idx_ff + RW'(1);
            if (idx_ff == RW'(ENTRIES - 1)) begin
               state_in = S_SCAN_LAST;
            end
         end
         S_SCAN_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            case (req_ff.op)
               frmt_pkg::OP_FIND, frmt_pkg::OP_REMOVE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  if (found_ff) begin
                     rsp_in.hit          = 1'b1;
                     rsp_in.slot         = SW'(best_slot_ff);
                     rsp_in.region_start = best_ent_ff.region_start;
                     rsp_in.region_end   = best_ent_ff.region_end;
                     rsp_in.region_width = best_ent_ff.region_width;
                     rsp_in.region_size  = best_ent_ff.region_size;
                     if (req_ff.op == frmt_pkg::OP_REMOVE) begin
                        rk_cmd   = frmt_pkg::RK_DROP;
                        count_in = count_ff - CW'(1);
                        if (best_rank_ff == '0) begin
                           top_in = aux_slot_ff;
                        end
                     end
                  end
               end
               frmt_pkg::OP_SAVE: begin
                  if (found_ff && (best_ent_ff.region_start == req_ff.address) &&
                      (best_ent_ff.region_width == req_ff.width)) begin
                     rk_cmd              = frmt_pkg::RK_RAISE;
                     top_in              = best_slot_ff;
                     rsp_strobe_in       = 1'b1;
                     rsp_in              = '0;
                     rsp_in.hit          = 1'b1;
                     rsp_in.slot         = SW'(best_slot_ff);
                     rsp_in.region_start = best_ent_ff.region_start;
                     rsp_in.region_end   = best_ent_ff.region_end;
                     rsp_in.region_width = best_ent_ff.region_width;
                     rsp_in.region_size  = req_ff.pixel_size;
                     if (best_ent_ff.region_size != req_ff.pixel_size) begin
                        wr_en               = 1'b1;
                        wr_data.region_size = req_ff.pixel_size;
                        rsp_in.resized      = 1'b1;
                     end
                  end else if (found_ff) begin
                     rk_cmd   = frmt_pkg::RK_DROP;
                     count_in = count_ff - CW'(1);
                     if (free_found_ff && (free_slot_ff < best_slot_ff)) begin
                        new_slot_in = free_slot_ff;
                     end else begin
                        new_slot_in = best_slot_ff;
                     end
                     state_in = S_CREATE;
                  end else if (count_ff == CW'(ENTRIES)) begin
                     rk_cmd      = frmt_pkg::RK_DROP;
                     rk_slot     = aux_slot_ff;
                     rk_rank     = aux_target;
                     count_in    = count_ff - CW'(1);
                     evict_in    = 1'b1;
                     new_slot_in = aux_slot_ff;
                     state_in    = S_CREATE;
                  end else begin
                     new_slot_in = free_slot_ff;
                     state_in    = S_CREATE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_CREATE: begin
            rk_cmd               = frmt_pkg::RK_INSERT;
            rk_slot              = new_slot_ff;
            wr_en                = 1'b1;
            wr_addr              = new_slot_ff;
            wr_data.region_start = req_ff.address;
            wr_data.region_end   = calc_end;
            wr_data.region_width = req_ff.width;
            wr_data.region_size  = req_ff.pixel_size;
            count_in             = count_ff + CW'(1);
            top_in               = new_slot_ff;
            rsp_strobe_in        = 1'b1;
            rsp_in               = '0;
            rsp_in.hit           = 1'b1;
            rsp_in.slot          = SW'(new_slot_ff);
            rsp_in.region_start  = req_ff.address;
            rsp_in.region_end    = calc_end;
            rsp_in.region_width  = req_ff.width;
            rsp_in.region_size   = req_ff.pixel_size;
            rsp_in.created       = 1'b1;
            rsp_in.evicted       = evict_ff;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_ff        <= 1'b0;
         count_ff      <= '0;
         top_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_ff        <= chk_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      best_slot_ff  <= best_slot_in;
      best_rank_ff  <= best_rank_in;
      best_ent_ff   <= best_ent_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      aux_slot_ff   <= aux_slot_in;
      new_slot_ff   <= new_slot_in;
      evict_ff      <= evict_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
